>>> hdl/bmhq_pkg.sv
// Shared types and codes for the binary max-heap queue.
// Used by bmhq_cell and binary_max_heap_queue; depends on nothing.
package bmhq_pkg;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 7;

    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_EMPTY = 2'd1,
        ERR_FULL  = 2'd2
    } t_err;

    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_ctl;

endpackage

>>> hdl/binary_max_heap_queue.sv
// Max-priority queue of signed words built as a row of sorted cells.
// Depends on bmhq_pkg and bmhq_cell.
//
// Input channel: i_valid, i_kind, i_value, with o_stall back to the sender.
// A beat with i_kind at push stores i_value; a beat with i_kind at pop removes
// and returns the largest stored value. Output channel: o_valid with
// o_popped_value, o_error, o_entry_count and o_is_empty, and i_stall from the
// receiver. Every input beat yields exactly one output beat.
// The result is registered: o_valid rises in the cycle after acceptance, and one
// beat is taken every cycle while the receiver keeps up. This rate is set by the
// row of cells: each cell compares the new value with its own word and shifts
// toward its neighbor in the same cycle, so a push or a pop needs no further step.
// A pop on an empty queue returns zero with the empty error, and a push on a
// full queue is dropped with the full error; neither changes the contents.
// Reset clears the entry count and the output valid flag; the cell words are
// left as they are and are never read before they are written.
// While a result waits and i_stall is high, the result holds and o_stall is
// raised, so no new beat is taken until the result leaves.
module binary_max_heap_queue #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic                                  i_kind,
    input  logic signed [bmhq_pkg::VALUE_W-1:0]   i_value,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [bmhq_pkg::VALUE_W-1:0]   o_popped_value,
    output logic [1:0]                            o_error,
    output logic [bmhq_pkg::COUNT_W-1:0]          o_entry_count,
    output logic                                  o_is_empty
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic                         accept;
    logic                         is_pop;
    logic                         full;
    logic                         empty;
    logic signed [DATA_WIDTH-1:0] new_value;
    bmhq_pkg::t_cell_ctl          ctl;

    logic [CNT_W-1:0]                     r_count;
    logic [CNT_W-1:0]                     n_count;
    logic                                 r_out_valid;
    logic                                 n_out_valid;
    logic signed [bmhq_pkg::VALUE_W-1:0]  r_popped;
    logic signed [bmhq_pkg::VALUE_W-1:0]  n_popped;
    bmhq_pkg::t_err                       r_error;
    bmhq_pkg::t_err                       n_error;

    logic signed [DATA_WIDTH-1:0] cell_value [CAPACITY];
    logic                         cell_take  [CAPACITY];

    assign o_stall   = r_out_valid && i_stall;
    assign accept    = i_valid && !o_stall;
    assign is_pop    = i_kind == bmhq_pkg::KIND_POP;
    assign full      = r_count == CNT_W'(CAPACITY);
    assign empty     = r_count == '0;
    assign new_value = DATA_WIDTH'($unsigned(i_value));
    assign ctl.push  = accept && !is_pop && !full;
    assign ctl.pop   = accept && is_pop && !empty;

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic signed [DATA_WIDTH-1:0] prev_value;
        logic                         prev_take;
        logic signed [DATA_WIDTH-1:0] next_value;

        if (k == 0) begin : g_first
            assign prev_value = new_value;
            assign prev_take  = 1'b0;
        end else begin : g_inner
            assign prev_value = cell_value[k-1];
            assign prev_take  = cell_take[k-1];
        end

        if (k == CAPACITY - 1) begin : g_last
            assign next_value = cell_value[k];
        end else begin : g_body
            assign next_value = cell_value[k+1];
        end

        bmhq_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .CNT_W      (CNT_W),
            .INDEX      (k)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (ctl),
            .i_count      (r_count),
            .i_new_value  (new_value),
            .i_prev_value (prev_value),
            .i_prev_take  (prev_take),
            .i_next_value (next_value),
            .o_value      (cell_value[k]),
            .o_take       (cell_take[k])
        );
    end

    always_comb begin
        n_count     = r_count;
        n_out_valid = r_out_valid && i_stall;
        n_popped    = r_popped;
        n_error     = r_error;
        if (accept) begin
            n_out_valid = 1'b1;
            n_popped    = '0;
            n_error     = bmhq_pkg::ERR_OK;
            priority if (ctl.push) begin
                n_count = r_count + CNT_W'(1);
            end else if (ctl.pop) begin
                n_count  = r_count - CNT_W'(1);
                n_popped = bmhq_pkg::VALUE_W'(cell_value[0]);
            end else if (is_pop) begin
                n_error = bmhq_pkg::ERR_EMPTY;
            end else begin
                n_error = bmhq_pkg::ERR_FULL;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_popped <= n_popped;
        r_error  <= n_error;
    end

    assign o_valid        = r_out_valid;
    assign o_popped_value = r_popped;
    assign o_error        = r_error;
    assign o_entry_count  = bmhq_pkg::COUNT_W'(r_count);
    assign o_is_empty     = r_count == '0;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("Entry count exceeds capacity.");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.pop |=> r_count == $past(r_count) - CNT_W'(1))
        else $error("A pop did not lower the entry count by one.");

    a_row_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count >= CNT_W'(2) |-> cell_value[0] >= cell_value[1])
        else $error("The first two cells are out of order.");

    a_full_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_error == bmhq_pkg::ERR_FULL) |-> full)
        else $error("Full error reported while the queue has room.");

    a_empty_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_error == bmhq_pkg::ERR_EMPTY) |-> empty)
        else $error("Empty error reported while the queue holds values.");

endmodule

>>> hdl/bmhq_cell.sv
// One storage cell of the sorted row that holds the queue contents.
// Depends on bmhq_pkg for the control struct.
module bmhq_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int CNT_W      = 7,
    parameter int INDEX      = 0
) (
    input  logic                         i_clk,
    input  bmhq_pkg::t_cell_ctl          i_ctl,
    input  logic [CNT_W-1:0]             i_count,
    input  logic signed [DATA_WIDTH-1:0] i_new_value,
    input  logic signed [DATA_WIDTH-1:0] i_prev_value,
    input  logic                         i_prev_take,
    input  logic signed [DATA_WIDTH-1:0] i_next_value,
    output logic signed [DATA_WIDTH-1:0] o_value,
    output logic                         o_take
);

    logic signed [DATA_WIDTH-1:0] r_value;
    logic signed [DATA_WIDTH-1:0] n_value;
    logic                         occupied;

    // The row is sorted with the largest value in cell zero, so the cells that
    // take part in a push form a contiguous tail of the row.
    assign occupied = CNT_W'(INDEX) < i_count;
    assign o_take   = !occupied || (i_new_value > r_value);
    assign o_value  = r_value;

    always_comb begin
        n_value = r_value;
        if (i_ctl.push) begin
            if (o_take) begin
                n_value = i_prev_take ? i_prev_value : i_new_value;
            end
        end else if (i_ctl.pop) begin
            n_value = i_next_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule
